// File: design/ovl_pkg.sv
package ovl_pkg;

    typedef enum logic [2:0] {
        FUNC_APPEND = 3'd0,
        FUNC_FIND   = 3'd1,
        FUNC_CHECK  = 3'd2,
        FUNC_INSERT = 3'd3,
        FUNC_DELETE = 3'd4,
        FUNC_SORT   = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_SORT_OUT,
        ST_SORT_IN,
        ST_DONE
    } state_t;

    // Signed order on two's complement words.
    function automatic logic less_signed(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

// File: design/ordered_value_list.sv
// Ordered value list held in one synchronous single-port-write memory.
// Check and append need no memory read; find, insert, delete and sort step
// through the entries with at most one memory access per cycle. One item is
// in flight at a time.
// The result waits in an output register. Reset (rst_n low, asynchronous)
// empties the list; memory is not cleared.
module ordered_value_list #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // func[2:0], item_value[34:3], slot[42:35], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // ok[0], fill[5:1], zeros
);
    import ovl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    state_t state_reg, state_next;
    logic [2:0]    func_reg, func_next;
    logic [31:0]   val_reg, val_next;
    logic [7:0]    slot_reg, slot_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;    // general index
    logic [CW-1:0] j_reg, j_next;    // sort inner index
    logic [31:0]   key_reg, key_next;
    logic          ok_reg, ok_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          ov_reg, ov_next;
    logic [7:0]    od_reg, od_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;

    ovl_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign s_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            ov_reg      <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ov_reg      <= ov_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        val_reg  <= val_next;
        slot_reg <= slot_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        key_reg  <= key_next;
        ok_reg   <= ok_next;
        od_reg   <= od_next;
    end

    // Next state and datapath; memory read data returns in the cycle after the address.
    always_comb
    begin
        state_next = state_reg;
        func_next = func_reg; val_next = val_reg; slot_next = slot_reg;
        cnt_next = cnt_reg; i_next = i_reg; j_next = j_reg; key_next = key_reg;
        ok_next = ok_reg; rd_pend_next = 1'b0;
        ov_next = ov_reg && !m_tready; od_next = od_reg;
        we = 1'b0; waddr = '0; wdata = val_reg; raddr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    func_next = s_tdata[2:0];
                    val_next  = s_tdata[34:3];
                    slot_next = s_tdata[42:35];
                    ok_next   = 1'b0;
                    i_next    = '0;
                    case (s_tdata[2:0])
                        FUNC_APPEND:
                        begin
                            if (cnt_reg < CW'(DEPTH))
                            begin
                                we = 1'b1; waddr = cnt_reg[AW-1:0]; wdata = s_tdata[34:3];
                                cnt_next = cnt_reg + 1'b1; ok_next = 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        FUNC_CHECK:
                        begin
                            ok_next = (s_tdata[42:35] != 8'd0) &&
                                      ({1'b0, s_tdata[42:35]} <= 9'(cnt_reg));
                            state_next = ST_DONE;
                        end
                        FUNC_INSERT:
                        begin
                            if ((s_tdata[42:35] != 8'd0) &&
                                ({1'b0, s_tdata[42:35]} <= 9'(cnt_reg)) &&
                                (cnt_reg < CW'(DEPTH)))
                            begin
                                i_next = cnt_reg; // copy down from tail
                                ok_next = 1'b1;
                                state_next = ST_SHIFT;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        FUNC_FIND, FUNC_DELETE: state_next = ST_SCAN;
                        FUNC_SORT:
                        begin
                            ok_next = 1'b1;
                            i_next = CW'(1);
                            state_next = ST_SORT_OUT;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Read entry i; compare when it returns.
                if (rd_pend_reg && rdata == val_reg)
                begin
                    ok_next = 1'b1;
                    if (func_reg == FUNC_DELETE)
                    begin
                        i_next = i_reg - 1'b1; // index of hit
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (i_reg < cnt_reg)
                begin
                    raddr = i_reg[AW-1:0];
                    rd_pend_next = 1'b1;
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                if (func_reg == FUNC_INSERT)
                begin
                    // write entries[i] = entries[i-1] down to slot-1
                    if (rd_pend_reg)
                    begin
                        we = 1'b1; waddr = i_reg[AW-1:0]; wdata = rdata;
                        i_next = i_reg - 1'b1;
                    end
                    else if (9'(i_reg) > 9'(slot_reg) - 9'd1)
                    begin
                        raddr = AW'(i_reg - 1'b1);
                        rd_pend_next = 1'b1;
                    end
                    else
                    begin
                        we = 1'b1; waddr = i_reg[AW-1:0]; wdata = val_reg;
                        cnt_next = cnt_reg + 1'b1;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    // delete: entries[i] = entries[i+1]
                    if (rd_pend_reg)
                    begin
                        we = 1'b1; waddr = i_reg[AW-1:0]; wdata = rdata;
                        i_next = i_reg + 1'b1;
                    end
                    else if (i_reg + 1'b1 < cnt_reg)
                    begin
                        raddr = AW'(i_reg + 1'b1);
                        rd_pend_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SORT_OUT:
            begin
                // Insertion sort: fetch key = entries[i].
                if (rd_pend_reg)
                begin
                    key_next = rdata;
                    j_next = i_reg;
                    state_next = ST_SORT_IN;
                end
                else if (i_reg < cnt_reg)
                begin
                    raddr = i_reg[AW-1:0];
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SORT_IN:
            begin
                if (rd_pend_reg)
                begin
                    if (less_signed(key_reg, rdata))
                    begin
                        we = 1'b1; waddr = j_reg[AW-1:0]; wdata = rdata;
                        j_next = j_reg - 1'b1;
                    end
                    else
                    begin
                        we = 1'b1; waddr = j_reg[AW-1:0]; wdata = key_reg;
                        i_next = i_reg + 1'b1;
                        state_next = ST_SORT_OUT;
                    end
                end
                else if (j_reg != '0)
                begin
                    raddr = AW'(j_reg - 1'b1);
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    we = 1'b1; waddr = '0; wdata = key_reg;
                    i_next = i_reg + 1'b1;
                    state_next = ST_SORT_OUT;
                end
            end
            ST_DONE:
            begin
                if (!ov_next)
                begin
                    ov_next = 1'b1;
                    od_next = {2'b00, 5'(cnt_reg), ok_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(DEPTH))
        else $error("count above depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("ready while busy");
endmodule

// File: design/ovl_mem.sv
module ovl_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
